// ===== src/assert_macros.svh =====
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Implication checked in the following cycle outside reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== src/cppb_pkg.sv =====
package cppb_pkg;

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_BYTE  = 2'd1,
      OP_CMAP  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_OPAQUE = 2'd0,
      MODE_TRANS  = 2'd1,
      MODE_SHADOW = 2'd2,
      MODE_OTHER  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TOP  = 3'd1,
      PH_LEN  = 3'd2,
      PH_PAD1 = 3'd3,
      PH_DATA = 3'd4,
      PH_PAD2 = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_SHRD   = 3'd1,
      ST_SHWR   = 3'd2,
      ST_MAINRD = 3'd3,
      ST_MAINWR = 3'd4
   } state_type;

   localparam logic [15:0] BLEND_MASK = 16'h7BDE;
   localparam logic [7:0]  END_MARK   = 8'hFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] left_offset;
      logic signed [15:0] top_offset;
      logic [14:0] patch_width;
      logic [14:0] patch_height;
      logic [1:0]  draw_mode;
      logic [7:0]  stream_byte;
      logic [7:0]  cmap_index;
      logic [15:0] cmap_value;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        accepted;
      logic [15:0] pixel_address;
      logic [15:0] pixel_value;
      logic        last;
   } rsp_type;

   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a & BLEND_MASK} + {1'b0, b & BLEND_MASK};
      return s[16:1];
   endfunction

endpackage

// ===== src/column_post_patch_blitter_top.sv =====
// channel  ports                       transfer
// -------  --------------------------  -----------------------------------
// input    start, busy, req_item       start high while busy low
// result   rsp_valid, rsp_item         one cycle per strobe, always taken
//
// A begin, a colormap load or a non-drawing stream byte is taken without
// leaving idle; only a begin has a result, shown in the cycle after it.
// A data byte steps through read issue, read and write; with a shadow
// write in frame the (+2,+2) read-modify-write runs first.
// Reset clears control state only; memories hold garbage until written.
// The receiver cannot stall: each result is shown for one cycle.
module column_post_patch_blitter_top
   import cppb_pkg::*;
#(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200,
   parameter int MAP_ENTRIES  = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);
`include "assert_macros.svh"

   localparam int FB_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int FB_AW    = $clog2(FB_DEPTH);
   localparam int MAP_AW   = $clog2(MAP_ENTRIES);

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] origin_x_ff, origin_x_in;
   logic [15:0] origin_y_ff, origin_y_in;
   mode_type    mode_ff, mode_in;
   logic [14:0] cols_ff, cols_in;
   logic [14:0] col_now_ff, col_now_in;
   logic [8:0]  row_now_ff, row_now_in;
   logic [7:0]  left_ff, left_in;
   logic [FB_AW-1:0] addr_ff, addr_in;
   logic [FB_AW-1:0] addr2_ff, addr2_in;
   logic        main_ok_ff, main_ok_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  byte_ff, byte_in;
   logic [15:0] src_ff, src_in;

   logic             fb_we;
   logic [FB_AW-1:0] fb_wa, fb_ra;
   logic [15:0]      fb_wd, fb_rd;
   logic             map_we;
   logic [MAP_AW-1:0] map_wa, map_ra;
   logic [15:0]      map_rd;

   logic        accept;
   logic [16:0] px, py;
   logic [17:0] xw, yh;
   logic        fits;
   logic [15:0] col, row;
   logic        ok_main, ok_shadow;
   logic [15:0] wval;

   cppb_ram #(.WIDTH(16), .DEPTH(FB_DEPTH)) u_frame (
      .clock(clock), .wr_en(fb_we), .wr_addr(fb_wa), .wr_data(fb_wd),
      .rd_addr(fb_ra), .rd_data(fb_rd)
   );

   cppb_ram #(.WIDTH(16), .DEPTH(MAP_ENTRIES)) u_cmap (
      .clock(clock), .wr_en(map_we), .wr_addr(map_wa), .wr_data(req_item.cmap_value),
      .rd_addr(map_ra), .rd_data(map_rd)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign px   = {req_item.pos_x[15], req_item.pos_x} - {req_item.left_offset[15],
                 req_item.left_offset};
   assign py   = {req_item.pos_y[15], req_item.pos_y} - {req_item.top_offset[15],
                 req_item.top_offset};
   assign xw   = {px[16], px} + {3'b000, req_item.patch_width};
   assign yh   = {py[16], py} + {3'b000, req_item.patch_height};
   assign fits = !px[16] && !py[16] && (xw <= 18'(FRAME_WIDTH)) && (yh <= 18'(FRAME_HEIGHT));

   assign col       = origin_x_ff + {1'b0, col_now_ff};
   assign row       = origin_y_ff + {7'd0, row_now_ff};
   assign ok_main   = (32'(col) < FRAME_WIDTH) && (32'(row) < FRAME_HEIGHT);
   assign ok_shadow = (mode_ff == MODE_SHADOW) && (32'(col) + 2 < FRAME_WIDTH)
                      && (32'(row) + 2 < FRAME_HEIGHT);

   assign map_we = accept && (req_item.operation == OP_CMAP);
   assign map_wa = req_item.cmap_index[MAP_AW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_item.operation == OP_BYTE && phase_ff == PH_DATA) begin
               state_in = ok_shadow ? ST_SHRD : ST_MAINRD;
            end
         end
         ST_SHRD:   state_in = ST_SHWR;
         ST_SHWR:   state_in = ST_MAINRD;
         ST_MAINRD: state_in = ST_MAINWR;
         ST_MAINWR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      mode_in      = mode_ff;
      cols_in      = cols_ff;
      col_now_in   = col_now_ff;
      row_now_in   = row_now_ff;
      left_in      = left_ff;
      addr_in      = addr_ff;
      addr2_in     = addr2_ff;
      main_ok_in   = main_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      fb_we        = 1'b0;
      fb_wa        = addr_ff;
      fb_wd        = '0;
      fb_ra        = addr_ff;
      map_ra       = '0;
      wval         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            map_ra = req_item.stream_byte[MAP_AW-1:0];
            if (accept) begin
               unique case (req_item.operation)
                  OP_BEGIN: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.accepted  = fits;
                     rsp_in.last      = 1'b1;
                     phase_in         = PH_IDLE;
                     if (fits) begin
                        origin_x_in = px[15:0];
                        origin_y_in = py[15:0];
                        mode_in     = mode_type'(req_item.draw_mode);
                        cols_in     = req_item.patch_width;
                        col_now_in  = '0;
                        row_now_in  = '0;
                        left_in     = '0;
                        if (req_item.patch_width != '0) begin
                           phase_in = PH_TOP;
                        end
                     end
                  end
                  OP_BYTE: begin
                     unique case (phase_ff)
                        PH_TOP: begin
                           if (req_item.stream_byte == END_MARK) begin
                              col_now_in = col_now_ff + 15'd1;
                              if (col_now_in >= cols_ff) begin
                                 phase_in = PH_IDLE;
                              end
                           end else begin
                              row_now_in = {1'b0, req_item.stream_byte};
                              phase_in   = PH_LEN;
                           end
                        end
                        PH_LEN: begin
                           left_in  = req_item.stream_byte;
                           phase_in = PH_PAD1;
                        end
                        PH_PAD1: phase_in = (left_ff != '0) ? PH_DATA : PH_PAD2;
                        PH_DATA: begin
                           addr_in    = FB_AW'(32'(row) * FRAME_WIDTH + 32'(col));
                           addr2_in   = FB_AW'((32'(row) + 2) * FRAME_WIDTH + 32'(col) + 2);
                           main_ok_in = ok_main;
                           fb_ra      = ok_shadow ? addr2_in : addr_in;
                           if (!ok_shadow) begin
                              map_ra = req_item.stream_byte[MAP_AW-1:0];
                           end else begin
                              map_ra = '0;
                           end
                           row_now_in = row_now_ff + 9'd1;
                           left_in    = left_ff - 8'd1;
                           if (left_in == '0) begin
                              phase_in = PH_PAD2;
                           end
                        end
                        PH_PAD2: phase_in = PH_TOP;
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         ST_SHRD: begin
            // read the shadow pixel and map entry zero
            fb_ra  = addr2_ff;
            map_ra = '0;
         end
         ST_SHWR: begin
            wval                 = blend(fb_rd, map_rd);
            fb_we                = 1'b1;
            fb_wa                = addr2_ff;
            fb_wd                = wval;
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = 1'b1;
            rsp_in.pixel_address = 16'(addr2_ff);
            rsp_in.pixel_value   = wval;
            rsp_in.last          = !main_ok_ff;
            fb_ra                = addr_ff;
            map_ra               = byte_ff[MAP_AW-1:0];
         end
         ST_MAINRD: begin
            fb_ra = addr_ff;
         end
         ST_MAINWR: begin
            wval  = (mode_ff == MODE_TRANS) ? blend(fb_rd, src_ff) : src_ff;
            if (main_ok_ff) begin
               fb_we                = 1'b1;
               fb_wa                = addr_ff;
               fb_wd                = wval;
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = 1'b1;
               rsp_in.pixel_address = 16'(addr_ff);
               rsp_in.pixel_value   = wval;
               rsp_in.last          = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // capture the looked-up source color and the data byte
   always_comb begin
      byte_in = byte_ff;
      src_in  = src_ff;
      if (state_ff == ST_IDLE && accept) begin
         byte_in = req_item.stream_byte;
      end
      if (state_ff == ST_MAINRD) begin
         src_in = map_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         mode_ff      <= MODE_OPAQUE;
         cols_ff      <= '0;
         col_now_ff   <= '0;
         row_now_ff   <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         mode_ff      <= mode_in;
         cols_ff      <= cols_in;
         col_now_ff   <= col_now_in;
         row_now_ff   <= row_now_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff    <= addr_in;
      addr2_ff   <= addr2_in;
      main_ok_ff <= main_ok_in;
      rsp_ff     <= rsp_in;
      byte_ff    <= byte_in;
      src_ff     <= src_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_NEXT(a_shadow_seq, clock, reset, state_ff == ST_SHRD, state_ff == ST_SHWR,
                "shadow read not followed by shadow write")
   `ASSERT_IMPL(a_we_state, clock, reset, fb_we,
                state_ff == ST_SHWR || state_ff == ST_MAINWR, "frame write outside write state")
   `ASSERT_NEXT(a_wr_rsp, clock, reset, fb_we, rsp_valid,
                "frame write without result")
endmodule

// ===== src/cppb_ram.sv =====
module cppb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
